// ===== hdl/crt_pkg.sv =====
// Package: shared types, constants and helper functions for the Catmull-Rom tessellator.
`default_nettype none
package crt_pkg;
  localparam int unsigned MaxSteps = 63;
  localparam int unsigned StepW = 6;
  localparam int unsigned CoordW = 32;
  localparam int unsigned TW = 17;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    CfgSteps   = 1'b0,
    CfgSpacing = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // One segment job: a new-path flag and the four window points
  typedef struct packed {
    logic   new_path;
    point_t p1;
    point_t p2;
    point_t p3;
    point_t p4;
  } job_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkCoef,
    BkTime,
    BkHorner,
    BkDist,
    BkEmit
  } bk_state_e;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    begin
      hi = 68'sh7FFFFFFF;
      lo = -68'sh80000000;
      if (v > hi) sat32 = 32'sh7FFFFFFF;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[CoordW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== hdl/crt_front.sv =====
// Front part: keeps the control-point window and queues segment jobs.
`default_nettype none
module crt_front
  import crt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  begin_path_i,
  input  wire point_t pt_i,
  output logic       job_valid_o,
  input  wire logic  job_ready_i,
  output job_t       job_o
);
  point_t          win_q [4];
  logic [2:0]      held_q;
  logic            fresh_q;
  job_t            fifo_q [QDepth];
  logic            rd_q, wr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;
  point_t          w0, w1, w2;
  logic [2:0]      held_b;
  job_t            nj;

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rd_q];
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    held_b = begin_path_i ? 3'd0 : held_q;
    w0 = win_q[1];
    w1 = win_q[2];
    w2 = win_q[3];
    nj.new_path = fresh_q;
    nj.p1 = w0;
    nj.p2 = w1;
    nj.p3 = w2;
    nj.p4 = pt_i;
    push = in_valid_i && in_ready_o && (held_b >= 3'd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 3'd0;
      fresh_q <= 1'b0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (held_b < 3'd4) held_q <= held_b + 3'd1;
        else held_q <= held_b;
        // Mark the first job after a begin as the start of a path
        if (push) fresh_q <= 1'b0;
        else if (begin_path_i) fresh_q <= 1'b1;
      end
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Window shifts on every point; with fewer than four held the newest slot fills
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= pt_i;
      if (push) fifo_q[wr_q] <= nj;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= 3'd4)
    else $error("window count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> job_valid_o) else $error("pushed job not visible");
endmodule
`default_nettype wire

// ===== hdl/crt_back.sv =====
// Back part: samples a segment by Horner steps, filters by spacing and emits points.
`default_nettype none
module crt_back
  import crt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  output logic       job_ready_o,
  input  wire job_t  job_i,
  input  wire logic [StepW-1:0] steps_i,
  input  wire logic [CoordW-1:0] spacing_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output point_t     out_pt_o,
  output logic       out_last_o
);
  bk_state_e st_q, st_d;
  job_t      job_q;
  logic signed [35:0] a_q [3];
  logic signed [35:0] b_q [3];
  logic signed [33:0] c_q [3];
  logic [StepW-1:0]   s_q;
  logic [StepW-1:0]   i_q;
  logic [TW-1:0]      t_q;
  logic [16:0]        num_q;
  logic [5:0]         rem_q;
  logic [4:0]         dcnt_q;
  logic [TW-1:0]      tcnt_q;
  logic [1:0]         hstep_q;
  logic [1:0]         ax_q;
  logic signed [67:0] h_q [3];
  point_t             s_pt_q;
  point_t             last_q;
  logic               have_q;
  logic [1:0]         dax_q;
  logic [65:0]        dsum_q;
  logic               pend_q;
  point_t             pend_pt_q;
  logic               ov_q;
  point_t             ov_pt_q;
  logic               ov_last_q;
  logic               last_i;
  logic [6:0]         div_r;
  logic               div_ge;
  logic [TW-1:0]      div_q;
  logic [StepW-1:0]   i_nx;
  logic signed [CoordW-1:0] p2_ax;
  logic signed [39:0] hm;
  logic signed [57:0] prod;
  logic signed [67:0] rnd;
  logic signed [67:0] addend;
  logic signed [33:0] d;
  logic [32:0]        dm;
  logic [65:0]        sq;
  logic signed [67:0] hf;
  logic signed [CoordW-1:0] sres;

  assign job_ready_o = (st_q == BkIdle);
  assign out_valid_o = ov_q;
  assign out_pt_o = ov_pt_q;
  assign out_last_o = ov_last_q;
  assign last_i = (i_q == s_q);

  // Division step, Horner multiply (one axis per cycle) and squared distance per axis
  always_comb begin
    div_r = {rem_q, num_q[16]};
    div_ge = (div_r >= {1'b0, s_q});
    div_q = {tcnt_q[TW-2:0], div_ge};
    i_nx = i_q + StepW'(1);
    unique case (ax_q)
      2'd0:    p2_ax = job_q.p2.x;
      2'd1:    p2_ax = job_q.p2.y;
      default: p2_ax = job_q.p2.z;
    endcase
    hm = (hstep_q == 2'd0) ? 40'(a_q[ax_q]) : 40'(h_q[ax_q]);
    prod = 58'(hm) * $signed({1'b0, t_q});
    rnd = 68'((prod + 58'sd32768) >>> 16);
    unique case (hstep_q)
      2'd0:    addend = 68'(b_q[ax_q]);
      2'd1:    addend = 68'(c_q[ax_q]);
      default: addend = 68'sd2 * 68'(p2_ax);
    endcase
    hf = (rnd + addend + 68'sd1) >>> 1;
    sres = sat32(hf);
    unique case (dax_q)
      2'd0:    d = 34'(s_pt_q.x) - 34'(last_q.x);
      2'd1:    d = 34'(s_pt_q.y) - 34'(last_q.y);
      default: d = 34'(s_pt_q.z) - 34'(last_q.z);
    endcase
    dm = d[33] ? 33'(-d) : 33'(d);
    sq = 66'(dm) * 66'(dm);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkIdle:   if (job_valid_i) st_d = BkCoef;
      BkCoef:   st_d = BkTime;
      BkTime:   if (dcnt_q == 5'd16) st_d = BkHorner;
      BkHorner: if (hstep_q == 2'd2 && ax_q == 2'd2) st_d = BkDist;
      BkDist:   if (dax_q == 2'd2 || !have_q) st_d = BkEmit;
      BkEmit:   if (!pend_q || !ov_q || out_ready_i) st_d = last_i ? BkIdle : BkTime;
      default:  st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BkIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
      ov_last_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (st_q == BkIdle && job_valid_i && job_i.new_path) begin
        have_q <= 1'b0;
        pend_q <= 1'b0;
      end
      if (st_q == BkDist && st_d == BkEmit &&
          (!have_q || (dsum_q + ((dax_q == 2'd2 && have_q) ? sq : 66'd0))
           >= 66'(spacing_i))) begin
        if (pend_q) begin
          ov_q <= 1'b1;
          ov_last_q <= 1'b0;
        end
        pend_q <= 1'b1;
        have_q <= 1'b1;
      end
      if (st_q == BkEmit && st_d != BkEmit && last_i && pend_q) begin
        ov_q <= 1'b1;
        ov_last_q <= 1'b1;
        pend_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      BkIdle: begin
        job_q <= job_i;
        s_q <= (steps_i == '0) ? StepW'(1) : steps_i;
        i_q <= '0;
      end
      BkCoef: begin
        a_q[0] <= -36'(job_q.p1.x) + 36'sd3*36'(job_q.p2.x) - 36'sd3*36'(job_q.p3.x)
                  + 36'(job_q.p4.x);
        a_q[1] <= -36'(job_q.p1.y) + 36'sd3*36'(job_q.p2.y) - 36'sd3*36'(job_q.p3.y)
                  + 36'(job_q.p4.y);
        a_q[2] <= -36'(job_q.p1.z) + 36'sd3*36'(job_q.p2.z) - 36'sd3*36'(job_q.p3.z)
                  + 36'(job_q.p4.z);
        b_q[0] <= 36'sd2*36'(job_q.p1.x) - 36'sd5*36'(job_q.p2.x) + 36'sd4*36'(job_q.p3.x)
                  - 36'(job_q.p4.x);
        b_q[1] <= 36'sd2*36'(job_q.p1.y) - 36'sd5*36'(job_q.p2.y) + 36'sd4*36'(job_q.p3.y)
                  - 36'(job_q.p4.y);
        b_q[2] <= 36'sd2*36'(job_q.p1.z) - 36'sd5*36'(job_q.p2.z) + 36'sd4*36'(job_q.p3.z)
                  - 36'(job_q.p4.z);
        c_q[0] <= 34'(job_q.p3.x) - 34'(job_q.p1.x);
        c_q[1] <= 34'(job_q.p3.y) - 34'(job_q.p1.y);
        c_q[2] <= 34'(job_q.p3.z) - 34'(job_q.p1.z);
        num_q <= {1'b0, 11'd0, s_q[StepW-1:1]};
        rem_q <= '0;
        tcnt_q <= '0;
        dcnt_q <= '0;
      end
      BkTime: begin
        // Divide i*65536 + s/2 by s, one quotient bit a cycle; the numerator is
        // below s*2^17, so its top bits seed the remainder
        if (div_ge) rem_q <= 6'(div_r - {1'b0, s_q});
        else rem_q <= div_r[5:0];
        num_q <= {num_q[15:0], 1'b0};
        tcnt_q <= div_q;
        dcnt_q <= dcnt_q + 5'd1;
        if (st_d == BkHorner) begin
          t_q <= div_q;
          hstep_q <= 2'd0;
          ax_q <= 2'd0;
        end
      end
      BkHorner: begin
        if (hstep_q == 2'd2) begin
          unique case (ax_q)
            2'd0:    s_pt_q.x <= sres;
            2'd1:    s_pt_q.y <= sres;
            default: s_pt_q.z <= sres;
          endcase
        end else begin
          h_q[ax_q] <= rnd + addend;
        end
        if (ax_q == 2'd2) begin
          ax_q <= 2'd0;
          hstep_q <= hstep_q + 2'd1;
        end else begin
          ax_q <= ax_q + 2'd1;
        end
        dax_q <= 2'd0;
        dsum_q <= '0;
      end
      BkDist: begin
        dsum_q <= dsum_q + sq;
        dax_q <= dax_q + 2'd1;
        if (st_d == BkEmit &&
            (!have_q || (dsum_q + sq) >= 66'(spacing_i))) begin
          pend_pt_q <= s_pt_q;
          last_q <= s_pt_q;
          if (pend_q) ov_pt_q <= pend_pt_q;
        end
      end
      BkEmit: begin
        if (st_d != BkEmit) begin
          if (last_i && pend_q) ov_pt_q <= pend_pt_q;
          i_q <= i_nx;
          num_q <= {i_nx[0], 11'd0, s_q[StepW-1:1]};
          rem_q <= i_nx >> 1;
          tcnt_q <= '0;
          dcnt_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != BkIdle) |-> (s_q != '0)) else $error("zero step count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BkEmit && last_i && st_d == BkIdle) |=> !pend_q) else $error("point stuck");
endmodule
`default_nettype wire

// ===== hdl/catmull_rom_tessellator_top.sv =====
// Top level: configuration registers, front and back parts.
// A job passes a coefficient setup state, then each sample runs the t division, the Horner
// steps for each axis, a distance check (none for the first point of a path) and an emit state.
// A kept sample leaves once the next one is kept, or with tlast at the segment end.
// One job per control point once the window holds three; the back part takes one sample at a
// time, and a two-entry job queue decouples intake, which stalls only while the queue is full.
// Reset (rst_ni, async low) empties the window and queue; registers return to 8 and 1.
`default_nettype none
module catmull_rom_tessellator_top
  import crt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // ctrl_x, ctrl_y, ctrl_z
  input  wire logic         s_axis_tuser,  // begin_path
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,  // curve_x, curve_y, curve_z
  output logic              m_axis_tlast,  // run_last
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);
  logic [StepW-1:0]  steps_q;
  logic [CoordW-1:0] spacing_q;
  logic   job_valid, job_ready;
  job_t   job;
  point_t pin, pout;

  assign cfg_ready_o = 1'b1;
  assign pin.x = s_axis_tdata[31:0];
  assign pin.y = s_axis_tdata[63:32];
  assign pin.z = s_axis_tdata[95:64];
  assign m_axis_tdata = {pout.z, pout.y, pout.x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= StepW'(8);
      spacing_q <= 32'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSteps:   steps_q <= cfg_data_i[StepW-1:0];
        CfgSpacing: spacing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .begin_path_i(s_axis_tuser), .pt_i(pin),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  crt_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .steps_i(steps_q), .spacing_i(spacing_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_pt_o(pout), .out_last_o(m_axis_tlast)
  );
endmodule
`default_nettype wire
